// ----- rtl/lba_pkg.sv -----
// ----------------------------------------------------------------------------
// Linked block allocator package
// Shared widths, command codes and the control/status bundles that pass
// between the allocator's controller and datapath.
// ----------------------------------------------------------------------------
package lba_pkg;

    localparam int BLK_W          = 10;
    localparam int LEN_W          = 11;
    localparam int CNT_OUT_W      = 11;
    localparam int NUM_BLOCKS_DEF = 1024;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;   // clearing pass: free one map entry
        logic load;    // capture a new request
        logic check;   // evaluate the request and issue the first read
        logic scan;    // allocate scan step
        logic walk;    // release walk step
        logic finish;  // commit counts and present the result
    } t_lba_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic is_release;
        logic alloc_bad;
        logic len_zero;
        logic head_bad;
        logic alloc_last;
        logic walk_last;
    } t_lba_stat;

endpackage

// ----- rtl/linked_block_allocator.sv -----
// ----------------------------------------------------------------------------
// Linked block allocator
// Free map and linked block chains for a fixed pool of disk blocks.
// ----------------------------------------------------------------------------
// A command is transferred at a rising edge with start high and busy low.
// Allocate (command 0) takes the lowest-numbered free blocks, marks them used
// and links them in index order, after tail_block when has_chain is set.
// Release (command 1) walks the chain from head_block to tail_block and frees
// each block on it. Exactly one result per command is presented for a single
// cycle with o_result_valid high; the receiver cannot stall it.
// A rejected or zero-length allocate, or a release with an out-of-range head,
// finishes in the check state; otherwise an allocate scans the map in index
// order until its last block is taken, and a release walks the chain block
// by block. One map entry is read per cycle through the used-map memory
// port. The next command is accepted in the cycle its predecessor's result
// is shown.
// After reset busy stays high while a clearing pass marks every block free;
// the free count resets to NUM_BLOCKS.
// ----------------------------------------------------------------------------
module linked_block_allocator
    import lba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_command,
    input  logic [LEN_W-1:0]     i_request_length,
    input  logic                 i_has_chain,
    input  logic [BLK_W-1:0]     i_head_block,
    input  logic [BLK_W-1:0]     i_tail_block,
    output logic                 o_result_valid,
    output logic                 o_status,
    output logic [BLK_W-1:0]     o_first_block,
    output logic [BLK_W-1:0]     o_last_block,
    output logic [CNT_OUT_W-1:0] o_blocks_freed,
    output logic [CNT_OUT_W-1:0] o_free_blocks
);

    t_lba_cmd  cmd;
    t_lba_stat stat;

    lba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    lba_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_command        (i_command),
        .i_request_length (i_request_length),
        .i_has_chain      (i_has_chain),
        .i_head_block     (i_head_block),
        .i_tail_block     (i_tail_block),
        .o_result_valid   (o_result_valid),
        .o_status         (o_status),
        .o_first_block    (o_first_block),
        .o_last_block     (o_last_block),
        .o_blocks_freed   (o_blocks_freed),
        .o_free_blocks    (o_free_blocks)
    );

endmodule

// ----- rtl/lba_dp.sv -----
// ----------------------------------------------------------------------------
// Linked block allocator datapath
// Holds the used map and link memories, the free count, the scan and walk
// registers and the result registers.
// ----------------------------------------------------------------------------
module lba_dp
    import lba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_lba_cmd             i_cmd,
    output t_lba_stat            o_stat,
    input  logic                 i_command,
    input  logic [LEN_W-1:0]     i_request_length,
    input  logic                 i_has_chain,
    input  logic [BLK_W-1:0]     i_head_block,
    input  logic [BLK_W-1:0]     i_tail_block,
    output logic                 o_result_valid,
    output logic                 o_status,
    output logic [BLK_W-1:0]     o_first_block,
    output logic [BLK_W-1:0]     o_last_block,
    output logic [CNT_OUT_W-1:0] o_blocks_freed,
    output logic [CNT_OUT_W-1:0] o_free_blocks
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    logic             mem_used [NUM_BLOCKS];
    logic [IDX_W-1:0] mem_next [NUM_BLOCKS];

    logic             r_cmd;
    logic [LEN_W-1:0] r_len;
    logic [BLK_W-1:0] r_head;
    logic [BLK_W-1:0] r_tail;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_rd_addr;
    logic             r_used_rd;
    logic [IDX_W-1:0] r_next_rd;
    logic             r_fwd;
    logic [CNT_W-1:0] r_left;
    logic [IDX_W-1:0] r_prev;
    logic             r_have_prev;
    logic             r_prev_ok;
    logic [BLK_W-1:0] r_first;
    logic [BLK_W-1:0] r_last;
    logic [IDX_W-1:0] r_steps;
    logic [CNT_W-1:0] r_freed;
    logic [CNT_W-1:0] r_free;
    logic             r_valid;

    logic             used_eff;
    logic             take;
    logic             hit_walk;
    logic             walk_stop;
    logic             rel;
    logic [BLK_W-1:0] n_first;
    logic [BLK_W-1:0] n_last;
    logic [CNT_W-1:0] n_freed;
    logic [CNT_W-1:0] n_free;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             we_used;
    logic             wd_used;
    logic [IDX_W-1:0] wr_addr;
    logic             we_next;

    // A read issued at the address being cleared in the same cycle sees the
    // old entry; the forward flag masks it.
    assign used_eff = r_used_rd & ~r_fwd;
    assign take     = i_cmd.scan && !used_eff;
    assign hit_walk = i_cmd.walk && used_eff;
    assign rel      = (r_cmd == CMD_RELEASE);

    assign n_first = (take && !r_have_prev) ? BLK_W'(r_rd_addr) : r_first;
    assign n_last  = take ? BLK_W'(r_rd_addr) : r_last;
    assign n_freed = r_freed + CNT_W'(hit_walk);

    assign walk_stop = (32'(r_rd_addr) == 32'(r_tail))
                    || (32'(r_steps) == 32'(NUM_BLOCKS - 1))
                    || (32'(r_next_rd) >= 32'(NUM_BLOCKS));

    always_comb begin
        o_stat            = '0;
        o_stat.clr_last   = (r_idx == IDX_W'(NUM_BLOCKS - 1));
        o_stat.is_release = rel;
        o_stat.alloc_bad  = 32'(r_len) > 32'(r_free);
        o_stat.len_zero   = (r_len == '0);
        o_stat.head_bad   = 32'(r_head) >= 32'(NUM_BLOCKS);
        o_stat.alloc_last = take && (r_left == CNT_W'(1));
        o_stat.walk_last  = i_cmd.walk && walk_stop;
    end

    always_comb begin
        if (rel) begin
            n_free = r_free + n_freed;
        end else if (o_stat.alloc_bad) begin
            n_free = r_free;
        end else begin
            n_free = r_free - CNT_W'(r_len);
        end
    end

    // Memory port control.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (i_cmd.check) begin
            rd_en   = !rel || !o_stat.head_bad;
            rd_addr = rel ? IDX_W'(r_head) : '0;
        end else if (i_cmd.scan) begin
            rd_en   = 1'b1;
            rd_addr = (r_rd_addr == IDX_W'(NUM_BLOCKS - 1)) ? '0 : r_rd_addr + 1'b1;
        end else if (i_cmd.walk) begin
            rd_en   = !walk_stop;
            rd_addr = r_next_rd;
        end
    end

    always_comb begin
        we_used = 1'b0;
        wd_used = 1'b0;
        wr_addr = r_rd_addr;
        if (i_cmd.clear) begin
            we_used = 1'b1;
            wr_addr = r_idx;
        end else if (take) begin
            we_used = 1'b1;
            wd_used = 1'b1;
        end else if (hit_walk) begin
            we_used = 1'b1;
        end
    end

    assign we_next = take && r_prev_ok;

    always_ff @(posedge i_clk) begin
        if (we_used) begin
            mem_used[wr_addr] <= wd_used;
        end
        if (rd_en) begin
            r_used_rd <= mem_used[rd_addr];
            r_fwd     <= we_used && (wr_addr == rd_addr);
            r_rd_addr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_next) begin
            mem_next[r_prev] <= r_rd_addr;
        end
        if (rd_en) begin
            r_next_rd <= mem_next[rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_free  <= CNT_W'(NUM_BLOCKS);
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.clear) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.finish) begin
                r_free <= n_free;
            end
        end
    end

    // Request and walk registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd       <= i_command;
            r_len       <= i_request_length;
            r_head      <= i_head_block;
            r_tail      <= i_tail_block;
            r_left      <= CNT_W'(i_request_length);
            r_first     <= i_has_chain ? i_head_block : '0;
            r_last      <= i_has_chain ? i_tail_block : '0;
            r_have_prev <= i_has_chain;
            r_prev      <= IDX_W'(i_tail_block);
            r_prev_ok   <= i_has_chain && (32'(i_tail_block) < 32'(NUM_BLOCKS));
            r_freed     <= '0;
            r_steps     <= '0;
        end
        if (take) begin
            r_left      <= r_left - 1'b1;
            r_prev      <= r_rd_addr;
            r_prev_ok   <= 1'b1;
            r_have_prev <= 1'b1;
            r_first     <= n_first;
            r_last      <= n_last;
        end
        if (i_cmd.walk) begin
            r_freed <= n_freed;
            r_steps <= r_steps + 1'b1;
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_status       <= !rel && o_stat.alloc_bad;
            o_first_block  <= rel ? '0 : n_first;
            o_last_block   <= rel ? '0 : n_last;
            o_blocks_freed <= rel ? CNT_OUT_W'(n_freed) : '0;
            o_free_blocks  <= CNT_OUT_W'(n_free);
        end
    end

    assign o_result_valid = r_valid;

endmodule

// ----- rtl/lba_ctrl.sv -----
// ----------------------------------------------------------------------------
// Linked block allocator controller
// Sequences the clearing pass, request check, allocate scan and release walk.
// ----------------------------------------------------------------------------
module lba_ctrl
    import lba_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_lba_stat i_stat,
    output t_lba_cmd  o_cmd,
    output logic      o_busy
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_WALK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   n_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_stat.is_release) begin
                    if (i_stat.head_bad) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_WALK;
                    end
                end else if (i_stat.alloc_bad || i_stat.len_zero) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.alloc_last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

// ----- rtl/lba_checker.sv -----
// ----------------------------------------------------------------------------
// Linked block allocator checker
// Port-level properties of the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module lba_checker
    import lba_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_result_valid,
    input logic                 o_status,
    input logic [CNT_OUT_W-1:0] o_blocks_freed
);

    // Every command raises busy while it is evaluated.
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a command transfer");

    // No two results fall in consecutive cycles.
    a_result_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("results in consecutive cycles");

    a_no_result_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_result_valid)
        else $error("result in the cycle after a command transfer");

    // A rejected allocation frees nothing.
    a_reject_frees_nothing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status) |-> (o_blocks_freed == '0))
        else $error("rejected allocation reports freed blocks");

endmodule

bind linked_block_allocator lba_checker u_lba_checker (.*);
